### hw/rtl/bpq_pkg.sv
// Package for the button press qualifier: modes, register indexes, entry layout, defaults.
`timescale 1ns / 1ps

package bpq_pkg;

  // Request modes, carried on the slave tuser.
  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_READ   = 2'd1,
    MODE_INIT   = 2'd2
  } mode_e;

  // Configuration register indexes.
  localparam int unsigned CfgAddrW       = 1;
  localparam logic [CfgAddrW-1:0] CFG_DEBOUNCE   = 1'd0;
  localparam logic [CfgAddrW-1:0] CFG_LONG_PRESS = 1'd1;
  localparam int unsigned CfgDataW       = 16;

  localparam logic [CfgDataW-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CfgDataW-1:0] LONG_PRESS_RST = 16'd1000;

  // Clear mask bit positions in read mode.
  localparam int unsigned CLR_SHORT   = 0;
  localparam int unsigned CLR_RELEASE = 1;
  localparam int unsigned CLR_LONG    = 2;

  localparam int unsigned ButtonsDefault = 8;
  localparam int unsigned ButtonW        = 4;
  localparam int unsigned TimeW          = 32;

  // Per-button state word held in the state memory.
  typedef struct packed {
    logic             held;
    logic             prior;
    logic             short_latch;
    logic             release_latch;
    logic             long_latch;
    logic             long_done;
    logic             press_timing;
    logic [TimeW-1:0] change_time;
    logic [TimeW-1:0] press_time;
  } entry_t;

endpackage

### hw/rtl/button_press_qualifier.sv
// Top level: debounce and long-press qualifier over a per-button state memory.
// Requests pass the update stage registers, then the output register. Throughput: one request
// per cycle while m_axis_tready is high; the state memory read is registered and the write-back of
// the previous request is forwarded when both touch the same button.
// Reset: config returns to 50 ms debounce and 1000 ms long press, entry valid bits
// clear so every button reads as all zeros; no clearing pass is needed.
`timescale 1ns / 1ps

module button_press_qualifier #(
  parameter int unsigned BUTTONS = bpq_pkg::ButtonsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [bpq_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [bpq_pkg::CfgDataW-1:0] cfg_wdata_i,
  // request stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [39:0]                  s_axis_tdata,  // button[3:0], pin_level[4],
                                                      // time_ms[36:5], clear_mask[39:37]
  input  logic [1:0]                   s_axis_tuser,  // mode[1:0]
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata   // held[0], short_press[1],
                                                      // release_seen[2], long_press[3], zeros
);

  localparam int unsigned IdxW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  // ---------------- configuration ----------------
  logic [bpq_pkg::CfgDataW-1:0] debounce_q, long_press_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= bpq_pkg::DEBOUNCE_RST;
      long_press_q <= bpq_pkg::LONG_PRESS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        bpq_pkg::CFG_DEBOUNCE:   debounce_q   <= cfg_wdata_i;
        bpq_pkg::CFG_LONG_PRESS: long_press_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------- request fields ----------------
  logic [bpq_pkg::ButtonW-1:0] in_button;
  logic                        in_pin;
  logic [bpq_pkg::TimeW-1:0]   in_time;
  logic [2:0]                  in_mask;
  logic                        in_hit;
  logic [IdxW-1:0]             in_idx;
  logic                        in_acc;

  assign in_button = s_axis_tdata[3:0];
  assign in_pin    = s_axis_tdata[4];
  assign in_time   = s_axis_tdata[36:5];
  assign in_mask   = s_axis_tdata[39:37];
  assign in_hit    = ({1'b0, in_button} < 5'(BUTTONS));
  assign in_idx    = IdxW'(in_button);
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  // ---------------- update stage registers ----------------
  logic                      s1_valid_q;
  logic [1:0]                s1_mode_q;
  logic                      s1_hit_q;
  logic [IdxW-1:0]           s1_idx_q;
  logic                      s1_pressed_q;
  logic [bpq_pkg::TimeW-1:0] s1_time_q;
  logic [2:0]                s1_mask_q;

  logic                      out_valid_q;
  logic [3:0]                out_data_q;

  logic                      s1_fire;
  logic                      wr_en;
  bpq_pkg::entry_t           wr_entry;

  assign s1_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;

  // ---------------- state memory ----------------
  bpq_pkg::entry_t           mem [BUTTONS];
  logic [BUTTONS-1:0]        vld_q;
  bpq_pkg::entry_t           rd_data_q;
  logic                      rd_vld_q;
  logic                      fwd_q;
  bpq_pkg::entry_t           fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s1_idx_q] <= wr_entry;
    end
    if (in_acc) begin
      rd_data_q <= mem[in_idx];
    end
  end

  // Valid bits stand in for the all-zero reset of the memory.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[s1_idx_q] <= 1'b1;
      end
      if (in_acc) begin
        rd_vld_q <= vld_q[in_idx];
        // write to the same button this edge is missed by the read: forward it
        fwd_q    <= wr_en && (s1_idx_q == in_idx);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_data_q <= wr_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mode_q    <= s_axis_tuser;
      s1_hit_q     <= in_hit;
      s1_idx_q     <= in_idx;
      s1_pressed_q <= ~in_pin;
      s1_time_q    <= in_time;
      s1_mask_q    <= in_mask;
    end
  end

  // ---------------- read-modify-write ----------------
  bpq_pkg::entry_t           cur;
  bpq_pkg::entry_t           nxt;
  logic [3:0]                res;
  logic                      mode_ok;
  logic [bpq_pkg::TimeW-1:0] chg_diff;
  logic [bpq_pkg::TimeW-1:0] prs_diff;

  always_comb begin
    if (fwd_q) begin
      cur = fwd_data_q;
    end else if (rd_vld_q) begin
      cur = rd_data_q;
    end else begin
      cur = '0;
    end
  end

  always_comb begin
    nxt      = cur;
    mode_ok  = 1'b1;
    res      = '0;
    chg_diff = s1_time_q - cur.change_time;
    prs_diff = '0;
    unique case (s1_mode_q)
      bpq_pkg::MODE_SAMPLE: begin
        if ((s1_pressed_q != cur.held) &&
            (chg_diff > {{(bpq_pkg::TimeW-bpq_pkg::CfgDataW){1'b0}}, debounce_q})) begin
          nxt.prior       = cur.held;
          nxt.held        = s1_pressed_q;
          nxt.change_time = s1_time_q;
          if (s1_pressed_q) begin
            nxt.press_time    = s1_time_q;
            nxt.press_timing  = 1'b1;
            nxt.long_done     = 1'b0;
            nxt.short_latch   = 1'b1;
            nxt.long_latch    = 1'b0;
          end else begin
            nxt.release_latch = 1'b1;
            nxt.press_timing  = 1'b0;
            nxt.press_time    = '0;
            if (cur.long_done) begin
              nxt.long_done   = 1'b0;
              nxt.short_latch = 1'b0;
            end
          end
        end
        prs_diff = s1_time_q - nxt.press_time;
        if (nxt.held && !nxt.long_done && nxt.press_timing &&
            (prs_diff >= {{(bpq_pkg::TimeW-bpq_pkg::CfgDataW){1'b0}}, long_press_q})) begin
          nxt.long_latch  = 1'b1;
          nxt.long_done   = 1'b1;
          nxt.short_latch = 1'b0;
        end
        res = {nxt.long_latch, nxt.release_latch, nxt.short_latch, nxt.held};
      end
      bpq_pkg::MODE_READ: begin
        res = {cur.long_latch, cur.release_latch, cur.short_latch, cur.held};
        if (s1_mask_q[bpq_pkg::CLR_SHORT])   nxt.short_latch   = 1'b0;
        if (s1_mask_q[bpq_pkg::CLR_RELEASE]) nxt.release_latch = 1'b0;
        if (s1_mask_q[bpq_pkg::CLR_LONG])    nxt.long_latch    = 1'b0;
      end
      bpq_pkg::MODE_INIT: begin
        nxt               = '0;
        nxt.held          = s1_pressed_q;
        nxt.prior         = s1_pressed_q;
        nxt.change_time   = s1_time_q;
        res = {3'b000, s1_pressed_q};
      end
      default: begin
        mode_ok = 1'b0;
      end
    endcase
    if (!s1_hit_q) begin
      res = '0;
    end
  end

  assign wr_en    = s1_fire && s1_hit_q && mode_ok;
  assign wr_entry = nxt;

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_data_q <= (mode_ok ? res : 4'b0000);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_data_q};

endmodule
